@@ rtl/skvt_pkg.sv @@
// Package for the sorted key/value table.
// Holds the item types, operation codes and cell command codes shared by
// skvt_cell and sorted_key_value_table. No dependencies.
package skvt_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] key;
        logic [15:0] word_value;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [7:0]  entry_index;
        logic [15:0] stored_value;
        logic        is_relative;
    } out_item_t;

    // Per-cell record moved down the chain while the search result is gathered
    typedef struct packed {
        logic        mark;
        logic        eq;
        logic [15:0] value;
        logic        rel;
    } scan_t;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOOKUP  = 2'd0;
    localparam op_t OP_PUT_ABS = 2'd1;
    localparam op_t OP_PUT_REL = 2'd2;
    localparam op_t OP_REMOVE  = 2'd3;

    typedef logic [2:0] cell_cmd_t;
    localparam cell_cmd_t CMD_HOLD      = 3'd0;
    localparam cell_cmd_t CMD_CMP       = 3'd1;
    localparam cell_cmd_t CMD_LOAD      = 3'd2;
    localparam cell_cmd_t CMD_SCAN      = 3'd3;
    localparam cell_cmd_t CMD_INSERT    = 3'd4;
    localparam cell_cmd_t CMD_OVERWRITE = 3'd5;
    localparam cell_cmd_t CMD_REMOVE    = 3'd6;

    // Cells read by the result gatherer in each scan cycle
    localparam int SCAN_LANES = 16;

endpackage

@@ rtl/skvt_cell.sv @@
// One entry of the sorted table: key, value and flag, with its compare flags
// and the scan record. Depends on skvt_pkg.
module skvt_cell #(
    parameter int KEY_BITS = 20,
    parameter int CNT_BITS = 9,
    parameter int IDX      = 0
) (
    input  logic                  clk,
    input  skvt_pkg::cell_cmd_t   cmd,
    input  logic [KEY_BITS-1:0]   key,
    input  logic [15:0]           word_value,
    input  logic                  rel,
    input  logic [CNT_BITS-1:0]   count,
    input  logic                  prev_lt,
    input  logic [KEY_BITS-1:0]   prev_key,
    input  logic [15:0]           prev_value,
    input  logic                  prev_rel,
    input  logic [KEY_BITS-1:0]   next_key,
    input  logic [15:0]           next_value,
    input  logic                  next_rel,
    input  skvt_pkg::scan_t       scan_in,
    output logic [KEY_BITS-1:0]   key_q,
    output logic [15:0]           value_q,
    output logic                  rel_q,
    output logic                  lt,
    output skvt_pkg::scan_t       scan_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [15:0]         value_reg;
    logic                rel_reg;
    logic                lt_reg;
    logic                eq_reg;
    skvt_pkg::scan_t     scan_reg;
    logic                live;
    logic                mark;

    assign live = CNT_BITS'(IDX) < count;
    // First cell whose key is not below the search key
    assign mark = !lt_reg && prev_lt;

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            skvt_pkg::CMD_HOLD:
            begin
            end
            skvt_pkg::CMD_CMP:
            begin
                lt_reg <= live && (key_reg < key);
                eq_reg <= live && (key_reg == key);
            end
            skvt_pkg::CMD_LOAD:
            begin
                scan_reg.mark  <= mark;
                scan_reg.eq    <= eq_reg;
                scan_reg.value <= value_reg;
                scan_reg.rel   <= rel_reg;
            end
            skvt_pkg::CMD_SCAN:
            begin
                scan_reg <= scan_in;
            end
            skvt_pkg::CMD_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (mark)
                    begin
                        key_reg   <= key;
                        value_reg <= word_value;
                        rel_reg   <= rel;
                    end
                    else
                    begin
                        key_reg   <= prev_key;
                        value_reg <= prev_value;
                        rel_reg   <= prev_rel;
                    end
                end
            end
            skvt_pkg::CMD_OVERWRITE:
            begin
                if (eq_reg)
                begin
                    value_reg <= word_value;
                    rel_reg   <= rel;
                end
            end
            skvt_pkg::CMD_REMOVE:
            begin
                if (!lt_reg)
                begin
                    key_reg   <= next_key;
                    value_reg <= next_value;
                    rel_reg   <= next_rel;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign key_q    = key_reg;
    assign value_q  = value_reg;
    assign rel_q    = rel_reg;
    assign lt       = lt_reg;
    assign scan_out = scan_reg;

endmodule

@@ rtl/sorted_key_value_table.sv @@
// Sorted key/value table: top level with the cell chain and its sequencer.
// Depends on skvt_pkg and skvt_cell.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | to block  | in_valid / in_ready  | in_item  (op, key, value)
//   out     | from block| out_valid / out_ready| out_item (result)
//
// A result follows the compare, load, scan and update states. The scan walks
// the compare flags down the chain in 16-cell groups until the insertion
// point is seen or the last group is reached (1 to ceil(DEPTH/16) groups).
// One item is in flight at a time; in_ready is high only in idle, so a new
// item is taken once the last is done. Reset clears the control registers only.
// A stalled output holds the finished item and the table update until taken.
module sorted_key_value_table #(
    parameter int DEPTH    = 256,
    parameter int KEY_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  skvt_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output skvt_pkg::out_item_t  out_item
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int LANES    = (DEPTH < skvt_pkg::SCAN_LANES) ? DEPTH : skvt_pkg::SCAN_LANES;
    localparam int NGROUPS  = (DEPTH + LANES - 1) / LANES;
    localparam int GRP_BITS = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int LANE_BITS = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_APPLY = 3'd4;

    logic [2:0]             state_reg, state_next;
    skvt_pkg::op_t          op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [15:0]            val_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [GRP_BITS-1:0]    grp_reg, grp_next;
    logic                   hit_reg;
    logic [CNT_BITS-1:0]    pos_reg;
    logic [15:0]            sval_reg;
    logic                   srel_reg;
    skvt_pkg::out_item_t    out_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [63:0]            key_wide;
    logic                   rel_new;
    logic                   is_put;
    logic                   full;
    logic                   out_free;
    skvt_pkg::cell_cmd_t    cmd;
    skvt_pkg::cell_cmd_t    apply_cmd;
    skvt_pkg::out_item_t    result;

    logic [KEY_BITS-1:0]    c_key   [DEPTH];
    logic [15:0]            c_value [DEPTH];
    logic                   c_rel   [DEPTH];
    logic                   c_lt    [DEPTH];
    skvt_pkg::scan_t        c_scan  [DEPTH];

    logic                   lane_hit;
    logic [LANE_BITS-1:0]   lane_idx;
    logic                   lane_eq;
    logic [15:0]            lane_val;
    logic                   lane_rel;
    logic [CNT_BITS-1:0]    lane_pos;

    // ---------------- cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                prev_lt;
            logic [KEY_BITS-1:0] prev_key;
            logic [15:0]         prev_value;
            logic                prev_rel;
            logic [KEY_BITS-1:0] next_key;
            logic [15:0]         next_value;
            logic                next_rel;
            skvt_pkg::scan_t     scan_in;

            if (gi == 0)
            begin : g_first
                assign prev_lt    = 1'b1;
                assign prev_key   = '0;
                assign prev_value = '0;
                assign prev_rel   = 1'b0;
            end
            else
            begin : g_mid
                assign prev_lt    = c_lt[gi-1];
                assign prev_key   = c_key[gi-1];
                assign prev_value = c_value[gi-1];
                assign prev_rel   = c_rel[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_key   = '0;
                assign next_value = '0;
                assign next_rel   = 1'b0;
            end
            else
            begin : g_nxt
                assign next_key   = c_key[gi+1];
                assign next_value = c_value[gi+1];
                assign next_rel   = c_rel[gi+1];
            end

            if (gi + LANES < DEPTH)
            begin : g_scan
                assign scan_in = c_scan[gi+LANES];
            end
            else
            begin : g_scan_end
                assign scan_in = '0;
            end

            skvt_cell #(
                .KEY_BITS (KEY_BITS),
                .CNT_BITS (CNT_BITS),
                .IDX      (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .key        (key_reg),
                .word_value (val_reg),
                .rel        (rel_new),
                .count      (count_reg),
                .prev_lt    (prev_lt),
                .prev_key   (prev_key),
                .prev_value (prev_value),
                .prev_rel   (prev_rel),
                .next_key   (next_key),
                .next_value (next_value),
                .next_rel   (next_rel),
                .scan_in    (scan_in),
                .key_q      (c_key[gi]),
                .value_q    (c_value[gi]),
                .rel_q      (c_rel[gi]),
                .lt         (c_lt[gi]),
                .scan_out   (c_scan[gi])
            );
        end
    endgenerate

    // ---------------- scan gatherer: lanes at the head of the chain ----------------
    always_comb
    begin
        lane_hit = 1'b0;
        lane_idx = '0;
        lane_eq  = 1'b0;
        lane_val = '0;
        lane_rel = 1'b0;
        for (int j = 0; j < LANES; j++)
        begin
            if (c_scan[j].mark)
            begin
                lane_hit = 1'b1;
                lane_idx = LANE_BITS'(j);
                lane_eq  = c_scan[j].eq;
                lane_val = c_scan[j].value;
                lane_rel = c_scan[j].rel;
            end
        end
        lane_pos = CNT_BITS'(grp_reg) * CNT_BITS'(LANES) + CNT_BITS'(lane_idx);
    end

    // ---------------- sequencer ----------------
    assign key_wide = 64'(in_item.key);
    assign rel_new  = (op_reg == skvt_pkg::OP_PUT_REL);
    assign is_put   = (op_reg == skvt_pkg::OP_PUT_ABS) || (op_reg == skvt_pkg::OP_PUT_REL);
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        apply_cmd = skvt_pkg::CMD_HOLD;
        if (is_put && hit_reg)
            apply_cmd = skvt_pkg::CMD_OVERWRITE;
        else if (is_put && !full)
            apply_cmd = skvt_pkg::CMD_INSERT;
        else if ((op_reg == skvt_pkg::OP_REMOVE) && hit_reg)
            apply_cmd = skvt_pkg::CMD_REMOVE;

        result.status       = is_put && !hit_reg && full;
        result.found        = hit_reg;
        result.entry_index  = 8'(pos_reg);
        result.stored_value = sval_reg;
        result.is_relative  = srel_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        grp_next       = grp_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = skvt_pkg::CMD_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd        = skvt_pkg::CMD_CMP;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd        = skvt_pkg::CMD_LOAD;
                grp_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd = skvt_pkg::CMD_SCAN;
                if (lane_hit || grp_reg == GRP_BITS'(NGROUPS - 1))
                    state_next = S_APPLY;
                else
                    grp_next = grp_reg + 1'b1;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    cmd            = apply_cmd;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (apply_cmd == skvt_pkg::CMD_INSERT)
                        count_next = count_reg + 1'b1;
                    else if (apply_cmd == skvt_pkg::CMD_REMOVE)
                        count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            grp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= in_item.op;
            key_reg <= key_wide[KEY_BITS-1:0];
            val_reg <= in_item.word_value;
        end
        if (state_reg == S_SCAN)
        begin
            if (lane_hit)
            begin
                hit_reg  <= lane_eq;
                pos_reg  <= lane_pos;
                sval_reg <= lane_eq ? lane_val : 16'd0;
                srel_reg <= lane_eq && lane_rel;
            end
            else
            begin
                // no insertion point in the chain: key above every entry
                hit_reg  <= 1'b0;
                pos_reg  <= count_reg;
                sval_reg <= 16'd0;
                srel_reg <= 1'b0;
            end
        end
        if (state_reg == S_APPLY && out_free)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count above capacity");

    a_refused_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status |-> !out_item.found)
        else $error("refused put reports a present key");

    a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg == S_APPLY))
        else $error("entry count changed outside the update step");

    a_accept_starts_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_CMP)
        else $error("accepted item did not start a compare");

    a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY && out_free |=> out_valid && state_reg == S_IDLE)
        else $error("update step did not present a result");

endmodule
